/* hdl/pclb_pkg.sv */
package pclb_pkg;

    localparam int unsigned KEY_W   = 64;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned ULVL_W  = 16;
    localparam int unsigned BLVL_W  = 38;
    localparam int unsigned ULIM_W  = 10;
    localparam int unsigned BLIM_W  = 32;
    localparam int unsigned IDX_OUT_W = 6;

    localparam logic [ULVL_W-1:0] UPLOAD_SCALE = 16'd60;
    localparam logic [ULIM_W-1:0] UPLOAD_LIMIT_RST = 10'd30;
    localparam logic [BLIM_W-1:0] BYTE_LIMIT_RST = 32'd67108864;

    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_UPLOAD_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_LIMIT   = 1'b1;

    localparam logic FUNC_UPLOAD = 1'b0;
    localparam logic FUNC_BYTES  = 1'b1;

    // One slot as it lies in memory.
    localparam int unsigned SLOT_W = 2*KEY_W + TIME_W + ULVL_W + BLVL_W;

    typedef struct packed {
        logic [KEY_W-1:0]  key_high;
        logic [KEY_W-1:0]  key_low;
        logic [TIME_W-1:0] stamp;
        logic [ULVL_W-1:0] upload_level;
        logic [BLVL_W-1:0] byte_level;
    } t_slot;

    typedef struct packed {
        logic              func;
        logic [KEY_W-1:0]  key_high;
        logic [KEY_W-1:0]  key_low;
        logic [TIME_W-1:0] now_seconds;
        logic [31:0]       byte_count;
    } t_req;

    typedef struct packed {
        logic                 allowed;
        logic [IDX_OUT_W-1:0] slot_used;
        logic                 was_new;
    } t_rsp;

endpackage

/* hdl/pclb_ram.sv */
module pclb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/per_client_leaky_bucket_limiter.sv */
// After reset a clearing pass zeroes every slot; start is refused meanwhile.
// After acceptance the scan reads one slot per cycle and stops at a key match or at the
// last slot. Then come a re-read, a read wait, a multiply stage, the update with its write
// and a state to register the result; the strobe follows, sooner on an early hit. The next
// item can be accepted in the strobe cycle, not before; no receiver stalls.
// Reset (synchronous, active low) restores the limits and zeroes every slot.
module per_client_leaky_bucket_limiter
    import pclb_pkg::*;
#(
    parameter int unsigned SLOT_COUNT = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_req                 i_req,
    output logic                 o_valid,
    output t_rsp                 o_rsp,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BLIM_W-1:0]    i_cfg_data
);

    localparam int unsigned AW = $clog2(SLOT_COUNT);
    localparam int unsigned CW = AW + 1;
    localparam logic [CW-1:0] LAST = CW'(SLOT_COUNT);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_SCAN  = 8'b0000_0100,
        S_READ  = 8'b0000_1000,
        S_WAIT  = 8'b0001_0000,
        S_MUL   = 8'b0010_0000,
        S_DRAIN = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic [ULIM_W-1:0] r_ulim;
    logic [BLIM_W-1:0] r_blim;
    t_req              r_req;
    logic [CW-1:0]     r_cnt;      // read address issued
    logic              r_rvld;     // read data valid this cycle
    logic [AW-1:0]     r_raddr_q;  // address of data now on rdata
    logic              r_hit;
    logic [AW-1:0]     r_idx;
    logic [AW-1:0]     r_old;
    logic [TIME_W-1:0] r_old_t;
    t_slot             r_slot;
    logic [41:0]       r_udr;      // elapsed * upload_limit
    logic [63:0]       r_bdr;      // elapsed * byte_limit
    logic [BLVL_W:0]   r_bchg;     // byte_count * 60
    logic              r_valid;
    t_rsp              r_rsp;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    t_slot         ram_wdata, ram_rdata;

    pclb_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_COUNT)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    logic match;
    assign match = r_rvld && ram_rdata.key_high == r_req.key_high
                   && ram_rdata.key_low == r_req.key_low;

    // Final update, from the slot read back (or a fresh slot on a miss).
    t_slot            s0, fin;
    logic [ULVL_W-1:0] u_dr;
    logic [BLVL_W-1:0] b_dr;
    logic [ULVL_W:0]   u_want;
    logic [BLVL_W:0]   b_want;
    logic [ULVL_W+5:0] u_cap;
    logic [BLVL_W+1:0] b_cap;
    logic              ok, adv;

    always_comb begin
        s0 = r_slot;
        adv = r_req.now_seconds > s0.stamp;
        u_dr = (adv && r_udr >= 42'(s0.upload_level)) ? '0 :
               (adv ? s0.upload_level - ULVL_W'(r_udr) : s0.upload_level);
        b_dr = (adv && r_bdr >= 64'(s0.byte_level)) ? '0 :
               (adv ? s0.byte_level - BLVL_W'(r_bdr) : s0.byte_level);
        u_want = {1'b0, u_dr} + {1'b0, UPLOAD_SCALE};
        b_want = {1'b0, b_dr} + r_bchg;
        u_cap = (ULVL_W+6)'(r_ulim) * (ULVL_W+6)'(60);
        b_cap = {r_blim, 6'd0} - {2'd0, r_blim, 2'd0};
        if (r_req.func == FUNC_UPLOAD) begin
            ok = (ULVL_W+6)'(u_want) <= u_cap;
        end else begin
            ok = (BLVL_W+2)'(b_want) <= b_cap;
        end
        fin = s0;
        fin.key_high = r_req.key_high;
        fin.key_low = r_req.key_low;
        fin.upload_level = (ok && r_req.func == FUNC_UPLOAD) ? u_want[ULVL_W-1:0] : u_dr;
        fin.byte_level = (ok && r_req.func == FUNC_BYTES) ? b_want[BLVL_W-1:0] : b_dr;
        if (adv) begin
            fin.stamp = r_req.now_seconds;
        end
    end

    always_comb begin
        n_state = r_state;
        ram_we = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = fin;
        ram_raddr = r_cnt[AW-1:0];
        case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                ram_waddr = r_cnt[AW-1:0];
                ram_wdata = '0;
                if (r_cnt == LAST - CW'(1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                ram_raddr = '0;
                if (start) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (match || (r_rvld && r_raddr_q == AW'(SLOT_COUNT - 1))) n_state = S_READ;
            end
            S_READ: begin
                ram_raddr = match ? r_raddr_q : (r_hit ? r_idx : r_old);
                n_state = S_WAIT;
            end
            S_WAIT:  n_state = S_MUL;
            S_MUL:   n_state = S_DRAIN;
            S_DRAIN: begin
                ram_we = 1'b1;
                n_state = S_DONE;
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign busy = r_state != S_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ulim <= UPLOAD_LIMIT_RST;
            r_blim <= BYTE_LIMIT_RST;
            r_cnt <= '0;
            r_rvld <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_DONE);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_UPLOAD_LIMIT: r_ulim <= i_cfg_data[ULIM_W-1:0];
                    CFG_BYTE_LIMIT:   r_blim <= i_cfg_data;
                    default: ;
                endcase
            end
            r_rvld <= (r_state == S_IDLE && start)
                      || (r_state == S_SCAN && !match && r_cnt != LAST);
            case (r_state)
                S_CLEAR: r_cnt <= (r_cnt == LAST - CW'(1)) ? '0 : r_cnt + CW'(1);
                S_IDLE:  r_cnt <= CW'(1);
                S_SCAN: begin
                    if (!match && r_cnt != LAST) begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_raddr_q <= ram_raddr;
        case (r_state)
            S_IDLE: begin
                r_req <= i_req;
                r_hit <= 1'b0;
                r_old <= '0;
            end
            S_SCAN: begin
                if (match) begin
                    r_hit <= 1'b1;
                    r_idx <= r_raddr_q;
                end else if (r_rvld) begin
                    // The first slot with the strictly smallest time wins.
                    if (r_raddr_q == '0 || ram_rdata.stamp < r_old_t) begin
                        r_old <= r_raddr_q;
                        r_old_t <= ram_rdata.stamp;
                    end
                end
            end
            S_READ: begin
                if (!r_hit && !match) r_idx <= r_old;
                r_bchg <= (BLVL_W+1)'({r_req.byte_count, 6'd0})
                          - (BLVL_W+1)'({r_req.byte_count, 2'd0});
            end
            S_WAIT: begin
                if (r_hit) begin
                    r_slot <= ram_rdata;
                end else begin
                    r_slot <= '{key_high: ram_rdata.key_high, key_low: ram_rdata.key_low,
                                stamp: r_req.now_seconds, upload_level: '0,
                                byte_level: '0};
                end
            end
            default: ;
        endcase
        if (r_state == S_MUL) begin
            r_udr <= 42'(r_req.now_seconds - r_slot.stamp) * 42'(r_ulim);
            r_bdr <= 64'(r_req.now_seconds - r_slot.stamp) * 64'(r_blim);
        end
        if (r_state == S_DRAIN) begin
            r_rsp <= '{allowed: ok, slot_used: IDX_OUT_W'(r_idx), was_new: !r_hit};
        end
    end

    assign o_valid = r_valid;
    assign o_rsp = r_rsp;

    a_valid_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE |=> o_valid)
        else $error("result strobe missing after update");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(r_state == S_SCAN || r_state == S_DRAIN))
        else $error("result strobe during work");
    a_write_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_DRAIN || r_state == S_CLEAR))
        else $error("stray memory write");

endmodule
